// ----- rtl/sha1sh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sha1sh_pkg;

  localparam int unsigned NumWords   = 16;
  localparam int unsigned NumBytes   = 64;
  localparam int unsigned NumRounds  = 80;
  localparam int unsigned NumDigest  = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  // first byte offset that no longer leaves room for the length
  localparam logic [5:0] LenOffset = 6'd56;
  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [2:0] LastWord  = 3'd4;
  localparam logic [7:0] PadByte   = 8'h80;

  typedef logic [0:NumWords-1][31:0]  block_t;
  typedef logic [0:NumBytes-1][7:0]   block_bytes_t;
  typedef logic [0:NumDigest-1][31:0] chain_t;

  // one block handed from the front to the back
  typedef struct packed {
    logic   last_blk;
    block_t words;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_FULL,
    F_PAD,
    F_LEN
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROUND,
    B_ADD,
    B_OUT
  } back_state_t;

  localparam chain_t ChainInit = {IV0, IV1, IV2, IV3, IV4};

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20)      k = K0;
    else if (rnd < 7'd40) k = K1;
    else if (rnd < 7'd60) k = K2;
    else                  k = K3;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20)      f = (b & c) ^ (~b & d);
    else if (rnd < 7'd40) f = b ^ c ^ d;
    else if (rnd < 7'd60) f = (b & c) ^ (b & d) ^ (c & d);
    else                  f = b ^ c ^ d;
    return f;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sha1sh_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sha1sh_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_byte_present,
  input  wire logic             in_end_of_message,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output sha1sh_pkg::job_t      push_job
);
  import sha1sh_pkg::*;

  front_state_t state_r, state_nxt;
  logic [63:0]  len_r, len_nxt;
  block_bytes_t blk_r, blk_nxt;
  logic         last_r, last_nxt;

  logic [5:0]   pos;
  block_bytes_t pad_bytes;
  block_t       pad_words;
  block_t       len_words;

  assign pos = len_r[8:3];

  // padded copy of the buffer: keep bytes below pos, marker at pos, zeros above
  always_comb begin
    for (int i = 0; i < NumBytes; i++) begin
      if (6'(i) < pos)       pad_bytes[i] = blk_r[i];
      else if (6'(i) == pos) pad_bytes[i] = PadByte;
      else                   pad_bytes[i] = 8'h00;
    end
    pad_words = block_t'(pad_bytes);
    pad_words[NumWords-2] = len_r[63:32];
    pad_words[NumWords-1] = len_r[31:0];
    len_words = '0;
    len_words[NumWords-2] = len_r[63:32];
    len_words[NumWords-1] = len_r[31:0];
  end

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    blk_nxt    = blk_r;
    last_nxt   = last_r;
    in_ready   = 1'b0;
    push_valid = 1'b0;
    push_job   = '{last_blk: 1'b0, words: block_t'(blk_r)};
    unique case (state_r)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          last_nxt = in_end_of_message;
          if (in_byte_present) begin
            blk_nxt[pos] = in_data_byte;
            len_nxt      = len_r + 64'd8;
          end
          if (in_byte_present && pos == LastByte) state_nxt = F_FULL;
          else if (in_end_of_message)             state_nxt = F_PAD;
        end
      end
      F_FULL: begin
        push_valid = 1'b1;
        if (push_ready) state_nxt = last_r ? F_PAD : F_IDLE;
      end
      F_PAD: begin
        push_valid = 1'b1;
        if (pos >= LenOffset) begin
          push_job = '{last_blk: 1'b0, words: block_t'(pad_bytes)};
          if (push_ready) state_nxt = F_LEN;
        end else begin
          push_job = '{last_blk: 1'b1, words: pad_words};
          if (push_ready) begin
            len_nxt   = '0;
            state_nxt = F_IDLE;
          end
        end
      end
      F_LEN: begin
        push_valid = 1'b1;
        push_job   = '{last_blk: 1'b1, words: len_words};
        if (push_ready) begin
          len_nxt   = '0;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      len_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/sha1sh_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sha1sh_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  sha1sh_pkg::job_t  push_job,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output sha1sh_pkg::job_t  pop_job
);
  import sha1sh_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t              mem_r [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]     count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (PtrW+1)'(QueueDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PtrW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PtrW'(1);
      if (do_push && !do_pop)      count_r <= count_r + (PtrW+1)'(1);
      else if (!do_push && do_pop) count_r <= count_r - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

`default_nettype wire

// ----- rtl/sha1sh_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sha1sh_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         pop_valid,
  output logic              pop_ready,
  input  sha1sh_pkg::job_t  pop_job,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [31:0]       out_digest_word,
  output logic [2:0]        out_word_number,
  output logic              out_digest_done
);
  import sha1sh_pkg::*;

  back_state_t state_r, state_nxt;
  block_t      win_r, win_nxt;
  chain_t      vars_r, vars_nxt;
  chain_t      chain_r, chain_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  idx_r, idx_nxt;

  logic        ovalid_r, ovalid_nxt;
  logic [31:0] oword_r, oword_nxt;
  logic [2:0]  onum_r, onum_nxt;
  logic        odone_r, odone_nxt;

  logic [31:0] sched_new, temp;

  // rolling 16-word schedule window and one round of the working variables
  always_comb begin
    logic [31:0] x;
    x         = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
    sched_new = {x[30:0], x[31]};
    temp      = {vars_r[0][26:0], vars_r[0][31:27]}
              + round_f(rnd_r, vars_r[1], vars_r[2], vars_r[3])
              + vars_r[4] + round_k(rnd_r) + win_r[0];
  end

  always_comb begin
    state_nxt  = state_r;
    win_nxt    = win_r;
    vars_nxt   = vars_r;
    chain_nxt  = chain_r;
    rnd_nxt    = rnd_r;
    last_nxt   = last_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    oword_nxt  = oword_r;
    onum_nxt   = onum_r;
    odone_nxt  = odone_r;
    pop_ready  = 1'b0;

    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          win_nxt   = pop_job.words;
          last_nxt  = pop_job.last_blk;
          vars_nxt  = chain_r;
          rnd_nxt   = '0;
          state_nxt = B_ROUND;
        end
      end
      B_ROUND: begin
        win_nxt  = {win_r[1:NumWords-1], sched_new};
        vars_nxt = {temp, vars_r[0], {vars_r[1][1:0], vars_r[1][31:2]},
                    vars_r[2], vars_r[3]};
        rnd_nxt  = rnd_r + 7'd1;
        if (rnd_r == LastRound) state_nxt = B_ADD;
      end
      B_ADD: begin
        for (int i = 0; i < NumDigest; i++) chain_nxt[i] = chain_r[i] + vars_r[i];
        idx_nxt   = '0;
        state_nxt = last_r ? B_OUT : B_IDLE;
      end
      B_OUT: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          oword_nxt  = chain_r[idx_r];
          onum_nxt   = idx_r;
          odone_nxt  = (idx_r == LastWord);
          if (idx_r == LastWord) begin
            chain_nxt = ChainInit;
            state_nxt = B_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      chain_r  <= ChainInit;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      chain_r  <= chain_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r   <= win_nxt;
    vars_r  <= vars_nxt;
    rnd_r   <= rnd_nxt;
    last_r  <= last_nxt;
    idx_r   <= idx_nxt;
    oword_r <= oword_nxt;
    onum_r  <= onum_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_digest_word = oword_r;
  assign out_word_number = onum_r;
  assign out_digest_done = odone_r;

endmodule

`default_nettype wire

// ----- rtl/sha1_stream_hasher_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// sha-1 digest of a byte stream. each input request carries one message byte
// (when in_byte_present is high) and an end flag; the end request may carry a
// final byte or none, and an end request with no bytes before it hashes the
// empty message. a front stage packs bytes big-endian into a 64-byte buffer at
// one request per cycle and, on a full block or on the end flag, hands whole
// blocks (padding and the 64-bit bit length added) to a two-block queue. a back
// stage loads each block, runs the 80 rounds of the compression at one round
// per cycle and then adds the result into the chaining value. in_ready drops
// for one cycle at each full-block hand-off and stays low while a block waits
// on a full queue. after the end request the front builds one padding block,
// or two when the last bytes leave no room for the length, and in_ready stays
// low until the queue has taken them. after the last block the five digest
// words leave in order on the out_ channel, word 0 first, with out_digest_done
// high on word 4, through an output register, then the chaining value returns
// to its initial constants so the next request starts a new message. the next
// message's bytes may be taken while a digest is still being delivered.
module sha1_stream_hasher_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input requests
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_end_of_message,
  // digest words
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_number,
  output logic             out_digest_done
);
  import sha1sh_pkg::*;

  // block hand-off between front and back
  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  job_t push_job, pop_job;

  // byte packing, length count and padding
  sha1sh_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_byte_present  (in_byte_present),
    .in_end_of_message(in_end_of_message),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_job         (push_job)
  );

  // two whole blocks of slack so the front keeps taking bytes during rounds
  sha1sh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job)
  );

  // 80-round compression, chaining value and digest output
  sha1sh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_job        (pop_job),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digest_word(out_digest_word),
    .out_word_number(out_word_number),
    .out_digest_done(out_digest_done)
  );

endmodule

`default_nettype wire

// ----- rtl/sha1sh_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sha1sh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_digest_word,
  input wire logic [2:0]  out_word_number,
  input wire logic        out_digest_done
);

  // no digest word right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // done flag only on the fifth word
  a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_digest_done |-> out_word_number == 3'd4)
    else $error("digest_done on a word other than the fifth");

  a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word_number <= 3'd4 && (out_digest_done || out_word_number != 3'd4))
    else $error("word_number out of range or fifth word without done");

  // words of one digest come in order
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_digest_done |=>
      !out_valid || out_word_number == $past(out_word_number) + 3'd1)
    else $error("digest words out of order");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_number))
    else $error("stalled digest word changed");

endmodule

bind sha1_stream_hasher_core sha1sh_checker u_sha1sh_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_digest_word  (out_digest_word),
  .out_word_number  (out_word_number),
  .out_digest_done  (out_digest_done)
);

`default_nettype wire

// ----- tb/tb_sha1_stream_hasher_core.sv -----
`timescale 1ns / 1ps

module tb_sha1_stream_hasher_core;

  import sha1sh_pkg::NumDigest;
  import sha1sh_pkg::LastWord;

  // stop after this many cycles in which neither channel moves anything
  localparam int unsigned StallLimit   = 5000;
  // settle time after the last digest word
  localparam int unsigned DrainCycles  = 300;
  localparam int unsigned RandomItems  = 180;
  localparam int unsigned IdlePercent  = 37;

  // sha-1 constants, kept apart from the design's own copies
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;
  localparam logic [31:0] RK0 = 32'h5a827999;
  localparam logic [31:0] RK1 = 32'h6ed9eba1;
  localparam logic [31:0] RK2 = 32'h8f1bbcdc;
  localparam logic [31:0] RK3 = 32'hca62c1d6;
  localparam logic [7:0]  PadMark  = 8'h80;
  localparam int unsigned LenSlot  = 56;
  localparam int unsigned LastSlot = 63;

  // one digest word as the out_ channel carries it
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  num;
    logic        done;
  } digest_beat_t;

  // running sha-1 of the accepted byte stream and the digest words still owed
  class sha1_scoreboard;
    logic [31:0]  chain [5];
    logic [31:0]  blk [16];
    logic [63:0]  bit_count;
    digest_beat_t owed_q [$];
    int unsigned  errors;
    int unsigned  words_checked;
    int unsigned  digests_predicted;

    function new();
      errors = 0;
      words_checked = 0;
      digests_predicted = 0;
      foreach (blk[i]) blk[i] = '0;
      restart();
    endfunction

    function void restart();
      chain = '{H0, H1, H2, H3, H4};
      bit_count = '0;
    endfunction

    function void put_byte(int unsigned pos, logic [7:0] b);
      blk[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = b;
    endfunction

    function void compress();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int r = 0; r < 16; r++) sched[r] = blk[r];
      for (int r = 16; r < 80; r++) begin
        t = sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16];
        sched[r] = {t[30:0], t[31]};
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int r = 0; r < 80; r++) begin
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = RK0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = RK1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = RK2;
        end else begin
          f = b ^ c ^ d;
          k = RK3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + sched[r];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    // called for every accepted input request
    function void note_request(logic [7:0] data_byte, logic present, logic eom);
      int unsigned pos;
      logic [63:0] len;
      if (present) begin
        pos = bit_count[8:3];
        put_byte(pos, data_byte);
        bit_count += 64'd8;
        if (pos == LastSlot) compress();
      end
      if (!eom) return;
      len = bit_count;
      pos = len[8:3];
      put_byte(pos, PadMark);
      for (int i = pos + 1; i <= LastSlot; i++) put_byte(i, 8'h00);
      if (pos >= LenSlot) begin
        compress();
        foreach (blk[i]) blk[i] = '0;
      end
      blk[14] = len[63:32];
      blk[15] = len[31:0];
      compress();
      for (int i = 0; i < NumDigest; i++)
        owed_q.push_back('{word: chain[i], num: 3'(i), done: (3'(i) == LastWord)});
      digests_predicted++;
      restart();
    endfunction

    // called for every accepted digest word
    function void check_word(logic [31:0] word, logic [2:0] num, logic done);
      digest_beat_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: digest word with none owed: got word %h num %0d done %b",
                 $time, word, num, done);
        return;
      end
      want = owed_q.pop_front();
      words_checked++;
      if (word !== want.word) begin
        errors++;
        $display("%0t: digest_word mismatch: expected %h actual %h", $time, want.word, word);
      end
      if (num !== want.num) begin
        errors++;
        $display("%0t: word_number mismatch: expected %0d actual %0d", $time, want.num, num);
      end
      if (done !== want.done) begin
        errors++;
        $display("%0t: digest_done mismatch: expected %b actual %b", $time, want.done, done);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_number;
  logic        out_digest_done;

  sha1_scoreboard sb;
  // high while both sides run back to back with no idle cycles
  bit          steady_flow;
  // requests that carry a byte or an end flag; empty ones are not counted
  int unsigned real_items;
  int unsigned messages_sent;

  sha1_stream_hasher_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_number   (out_word_number),
    .out_digest_done   (out_digest_done)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // digest receiver stalls at random except during the steady stretch
  initial out_ready <= 1'b0;
  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(99) >= IdlePercent);
  end

  // both handshakes are sampled here, input first so a digest is always
  // predicted before any of its words could be checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_request(in_data_byte, in_byte_present, in_end_of_message);
      if (out_valid && out_ready)
        sb.check_word(out_digest_word, out_word_number, out_digest_done);
    end
  end

  // watchdog: too long with nothing moving on either channel
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no handshake for %0d cycles, %0d digest words still owed",
             $time, StallLimit, sb.owed_q.size());
    $display("Regression FAIL");
    $finish;
  end

  // one request: random idle cycles first, then hold valid until taken
  task automatic send_request(input logic [7:0] data_byte, input logic present,
                              input logic eom);
    while (!steady_flow && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= data_byte;
    in_byte_present   <= present;
    in_end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    if (present || eom) real_items++;
  endtask

  // a whole message of random bytes; the last byte rides on the end request
  // or a byteless end request follows, and empty requests are sprinkled in
  task automatic send_message(input int unsigned n_bytes);
    bit tail_on_end;
    tail_on_end = (n_bytes != 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(9) == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
      send_request(8'($urandom_range(255)), 1'b1, tail_on_end && (i == n_bytes - 1));
    end
    if (!tail_on_end) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
    messages_sent++;
  endtask

  initial begin
    int unsigned directed_items;
    int unsigned msg_idx;
    int unsigned n_bytes;
    sb = new();
    steady_flow = 1'b0;
    real_items = 0;
    messages_sent = 0;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_data_byte      <= 8'h00;
    in_byte_present   <= 1'b0;
    in_end_of_message <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message straight after reset
    send_request(8'h00, 1'b0, 1'b1);
    // empty request must change nothing
    send_request(8'hff, 1'b0, 1'b0);
    // single all-ones byte carried on the end request
    send_request(8'hff, 1'b1, 1'b1);
    // zero byte, then a byteless end whose data byte must be ignored
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b1);
    // the classic "abc" vector
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    // alternating bit patterns with an empty request in the middle
    send_request(8'h55, 1'b1, 1'b0);
    send_request(8'h3c, 1'b0, 1'b0);
    send_request(8'haa, 1'b1, 1'b0);
    send_request(8'h5a, 1'b0, 1'b1);
    messages_sent += 5;
    directed_items = real_items;

    // random messages: first the one-short-of-length-slot and one-short-of-full
    // cases, then mostly short messages and some around the block boundary
    msg_idx = 0;
    while (real_items < directed_items + RandomItems) begin
      if (msg_idx == 0) n_bytes = LenSlot - 1;
      else if (msg_idx == 1) n_bytes = LastSlot;
      else if ($urandom_range(99) < 70) n_bytes = $urandom_range(10);
      else n_bytes = $urandom_range(LastSlot + 3, LenSlot - 4);
      // back to back traffic through the queue-full and overlap cases
      steady_flow = (msg_idx == 1) || (msg_idx == 2);
      send_message(n_bytes);
      msg_idx++;
    end
    steady_flow = 1'b0;
    in_valid <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("hashed %0d messages from %0d byte/end requests, empty and boundary lengths",
             messages_sent, real_items);
    $display("%0d digests predicted, %0d digest words checked, %0d mismatches",
             sb.digests_predicted, sb.words_checked, sb.errors);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sha1sh_pkg.sv
rtl/sha1sh_front.sv
rtl/sha1sh_queue.sv
rtl/sha1sh_back.sv
rtl/sha1_stream_hasher_core.sv
rtl/sha1sh_checker.sv
tb/tb_sha1_stream_hasher_core.sv
